FILE: sv/roulette_wheel_selector_defines.svh
`ifndef ROULETTE_WHEEL_SELECTOR_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RWS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rws_pkg.sv
`default_nettype none

package rws_pkg;

  localparam int FIT_W  = 32;
  localparam int RAND_W = 16;

  // Input op codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_DRAW   = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  // Command kinds passed from front to back
  localparam logic [1:0] KIND_NOP    = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_APPEND = 2'd2;
  localparam logic [1:0] KIND_DRAW   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [FIT_W-1:0] fitness_value;
    logic [RAND_W-1:0]       rand_fraction;
  } rws_in_t;

  typedef struct packed {
    logic [7:0] picked_index;
    logic       uniform_fallback;
    logic [1:0] status;
  } rws_out_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [FIT_W-1:0] fitness;
    logic [RAND_W-1:0]       rnd;
  } rws_cmd_t;

endpackage

`default_nettype wire

FILE: sv/roulette_wheel_selector.sv
// Roulette-wheel selector over a table of up to CAPACITY signed Q16.16
// fitness values. Each transfer on the in_ channel carries one op (clear,
// append, draw) and yields exactly one result on the out_ channel; a small
// command queue sits in front of the engine, and a registered output holds
// each result: the engine takes its next command in the cycle that the
// waiting result transfers. A draw steps through an offset multiply, the
// total, a sign check, a shift-add that scales the total by the random
// fraction and a scan of the entries walked before the slice is reached
// (at most the entry count), which the table's single read port serves
// one entry per cycle. A draw whose total is not positive skips the
// scaling and scan and picks uniformly. The table needs no clearing pass;
// only entries below the count are ever read.
`default_nettype none

`include "roulette_wheel_selector_defines.svh"

module roulette_wheel_selector #(
  parameter int CAPACITY = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire rws_pkg::rws_in_t in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output rws_pkg::rws_out_t     out_data,
  input  wire logic             out_stall
);
  import rws_pkg::*;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  rws_cmd_t push_cmd;
  rws_cmd_t head_cmd;

  rws_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .cmd      (push_cmd)
  );

  rws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd),
    .full       (q_full)
  );

  rws_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  `RWS_ASSERT_IMPLIES(a_empty_result, out_valid && out_data.status == ST_EMPTY, out_data.picked_index == 8'd0 && !out_data.uniform_fallback, "empty-table result not zero")
  `RWS_ASSERT_IMPLIES(a_full_result, out_valid && out_data.status == ST_FULL, out_data.picked_index == 8'd0 && !out_data.uniform_fallback, "full-table result not zero")
  `RWS_ASSERT_IMPLIES(a_fallback_ok, out_valid && out_data.uniform_fallback, out_data.status == ST_OK, "uniform pick with error status")
  `RWS_ASSERT_NEXT(a_push_lands, push, q_valid, "queued command lost")

endmodule

`default_nettype wire

FILE: sv/rws_front.sv
`default_nettype none

module rws_front (
  input  wire logic             in_valid,
  input  wire rws_pkg::rws_in_t in_data,
  input  wire logic             q_full,
  output logic                  in_stall,
  output logic                  push,
  output rws_pkg::rws_cmd_t     cmd
);
  import rws_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Decode the op; fields the command does not use are zeroed.
  always_comb begin
    cmd = '0;
    case (in_data.op)
      OP_CLEAR: begin
        cmd.kind = KIND_CLEAR;
      end
      OP_APPEND: begin
        cmd.kind    = KIND_APPEND;
        cmd.fitness = in_data.fitness_value;
      end
      OP_DRAW: begin
        cmd.kind = KIND_DRAW;
        cmd.rnd  = in_data.rand_fraction;
      end
      default: begin
        cmd.kind = KIND_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/rws_queue.sv
`default_nettype none

module rws_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rws_pkg::rws_cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   head_valid,
  output rws_pkg::rws_cmd_t      head_cmd,
  output logic                   full
);
  import rws_pkg::*;

  rws_cmd_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rws_back.sv
`default_nettype none

module rws_back #(
  parameter int CAPACITY = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire rws_pkg::rws_cmd_t cmd,
  output logic                   pop,
  output logic                   out_valid,
  output rws_pkg::rws_out_t      out_data,
  input  wire logic              out_stall
);
  import rws_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = FIT_W + CNT_W;
  localparam int TOT_W = SUM_W + 1;
  localparam int ACC_W = TOT_W + RAND_W;
  localparam int STEP_W = $clog2(RAND_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OFFM  = 3'd1;
  localparam logic [2:0] S_TOT   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic signed [FIT_W-1:0] mem [CAPACITY];

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [FIT_W-1:0] low_r, low_nxt;
  logic                    out_valid_r, out_valid_nxt;
  rws_out_t                out_data_r, out_data_nxt;
  logic [CNT_W-1:0]        iss_r, iss_nxt;
  logic                    chk_vld_r, chk_vld_nxt;

  logic [RAND_W-1:0]       rnd_r, rnd_nxt;
  logic [FIT_W-1:0]        offs_r, offs_nxt;
  logic [SUM_W-1:0]        offprod_r, offprod_nxt;
  logic signed [TOT_W-1:0] tot_r, tot_nxt;
  logic [IDX_W-1:0]        uni_r, uni_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [TOT_W-1:0]        pos_r, pos_nxt;
  logic [IDX_W-1:0]        chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]        res_idx_r, res_idx_nxt;
  logic                    res_fb_r, res_fb_nxt;
  logic signed [FIT_W-1:0] rd_data_r;

  logic                    slot_free;
  logic                    wr_en;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [CNT_W+RAND_W-1:0] uprod;
  logic [FIT_W:0]          ent_wide;
  logic [TOT_W-1:0]        pos_new;
  logic [TOT_W-1:0]        slice;
  logic [TOT_W-1:0]        tot_u;
  logic [IDX_W-1:0]        last_idx;
  logic [IDX_W+7:0]        idx_ext;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign uprod    = (CNT_W+RAND_W)'(cnt_r) * (CNT_W+RAND_W)'(rnd_r);
  assign ent_wide = {rd_data_r[FIT_W-1], rd_data_r} + {1'b0, offs_r};
  assign pos_new  = pos_r + TOT_W'(ent_wide[FIT_W-1:0]);
  assign slice    = acc_r[ACC_W-1:RAND_W];
  assign tot_u    = tot_r;
  assign last_idx = IDX_W'(cnt_r - 1'b1);
  assign idx_ext  = {8'b0, res_idx_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    low_nxt       = low_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    iss_nxt       = iss_r;
    chk_vld_nxt   = chk_vld_r;
    rnd_nxt       = rnd_r;
    offs_nxt      = offs_r;
    offprod_nxt   = offprod_r;
    tot_nxt       = tot_r;
    uni_nxt       = uni_r;
    acc_nxt       = acc_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    chk_idx_nxt   = chk_idx_r;
    res_idx_nxt   = res_idx_r;
    res_fb_nxt    = res_fb_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = iss_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (cmd.kind)
            KIND_CLEAR: begin
              cnt_nxt = '0;
              sum_nxt = '0;
              low_nxt = '0;
            end
            KIND_APPEND: begin
              if (cnt_r >= CNT_W'(CAPACITY)) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                sum_nxt = sum_r + {{CNT_W{cmd.fitness[FIT_W-1]}}, cmd.fitness};
                if (cnt_r == '0 || cmd.fitness < low_r) begin
                  low_nxt = cmd.fitness;
                end
              end
            end
            KIND_DRAW: begin
              if (cnt_r == '0) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rnd_nxt       = cmd.rnd;
                offs_nxt      = low_r[FIT_W-1] ? (~low_r + 1'b1) : '0;
                state_nxt     = S_OFFM;
              end
            end
            default: begin
              out_data_nxt = '0;
            end
          endcase
        end
      end
      S_OFFM: begin
        offprod_nxt = SUM_W'(offs_r) * SUM_W'(cnt_r);
        state_nxt   = S_TOT;
      end
      S_TOT: begin
        tot_nxt   = {sum_r[SUM_W-1], sum_r} + {1'b0, offprod_r};
        uni_nxt   = uprod[IDX_W+RAND_W-1:RAND_W];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (tot_r[TOT_W-1] || tot_r == '0) begin
          res_idx_nxt = uni_r;
          res_fb_nxt  = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          res_fb_nxt = 1'b0;
          acc_nxt    = '0;
          step_nxt   = '0;
          state_nxt  = S_SCALE;
        end
      end
      S_SCALE: begin
        // total * r, one bit of r per cycle, MSB first
        acc_nxt  = {acc_r[ACC_W-2:0], 1'b0} +
                   (rnd_r[RAND_W-1] ? ACC_W'(tot_u) : '0);
        rnd_nxt  = {rnd_r[RAND_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(RAND_W - 1)) begin
          iss_nxt     = '0;
          pos_nxt     = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        // reads issue one ahead of the accumulate
        if (iss_r < cnt_r) begin
          rd_en       = 1'b1;
          iss_nxt     = iss_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          pos_nxt = pos_new;
          if (pos_new >= slice || chk_idx_r == last_idx) begin
            res_idx_nxt = chk_idx_r;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.picked_index     = idx_ext[7:0];
          out_data_nxt.uniform_fallback = res_fb_r;
          out_data_nxt.status           = ST_OK;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      chk_vld_r   <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rnd_r      <= rnd_nxt;
    offs_r     <= offs_nxt;
    offprod_r  <= offprod_nxt;
    tot_r      <= tot_nxt;
    uni_r      <= uni_nxt;
    acc_r      <= acc_nxt;
    step_r     <= step_nxt;
    pos_r      <= pos_nxt;
    chk_idx_r  <= chk_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_fb_r   <= res_fb_nxt;
  end

  // Fitness table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= cmd.fitness;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sim/roulette_wheel_selector_checker.sv
`timescale 1ns / 1ps

module roulette_wheel_selector_checker #(
  parameter int CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  rws_pkg::rws_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rws_pkg::rws_out_t out_data,
  output int                fault_count,
  output int                owed_count
);

  import rws_pkg::*;

  // Shadow copy of the wheel
  logic signed [FIT_W-1:0] fit_tab [CAPACITY];
  int unsigned             n_entries;
  longint                  fit_total;   // 41-bit running sum fits easily
  logic signed [FIT_W-1:0] worst_fit;

  rws_out_t owed_picks [$];

  function automatic rws_out_t spin_wheel(input rws_in_t item);
    rws_out_t res;
    longint   shift;
    longint   wheel;
    longint   slice;
    longint   acc;
    bit       found;
    res = '0;
    case (item.op)
      OP_CLEAR: begin
        n_entries = 0;
        fit_total = 0;
        worst_fit = '0;
      end
      OP_APPEND: begin
        if (n_entries >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          fit_tab[n_entries] = item.fitness_value;
          if (n_entries == 0 || item.fitness_value < worst_fit) begin
            worst_fit = item.fitness_value;
          end
          n_entries++;
          fit_total += longint'(item.fitness_value);
        end
      end
      OP_DRAW: begin
        if (n_entries == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // if the worst entry is negative, lift every entry so it sits at zero
          shift = (worst_fit < 0) ? -longint'(worst_fit) : 64'sd0;
          wheel = fit_total + shift * longint'(n_entries);
          if (wheel <= 0) begin
            res.picked_index     = 8'((longint'(n_entries) * longint'(item.rand_fraction)) >>> 16);
            res.uniform_fallback = 1'b1;
          end else begin
            slice = (wheel * longint'(item.rand_fraction)) >>> 16;
            acc   = 0;
            found = 1'b0;
            res.picked_index = 8'(n_entries - 1);
            for (int i = 0; i < n_entries; i++) begin
              if (!found) begin
                acc += longint'(fit_tab[i]) + shift;
                if (acc >= slice) begin
                  res.picked_index = 8'(i);
                  found = 1'b1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic log_fault(input string what, input rws_out_t want, input rws_out_t got);
    if (fault_count < 10) begin
      $display("%0t ERROR %s: expected idx=%0d fb=%0d st=%0d, got idx=%0d fb=%0d st=%0d",
               $realtime, what, want.picked_index, want.uniform_fallback, want.status,
               got.picked_index, got.uniform_fallback, got.status);
    end
    fault_count++;
  endtask

  always @(posedge clk) begin
    rws_out_t want;
    if (!rst_n) begin
      n_entries = 0;
      fit_total = 0;
      worst_fit = '0;
      owed_picks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_picks.size() == 0) begin
          log_fault("result with nothing owed", '0, out_data);
        end else begin
          want = owed_picks.pop_front();
          if (out_data.picked_index !== want.picked_index ||
              out_data.uniform_fallback !== want.uniform_fallback ||
              out_data.status !== want.status) begin
            log_fault("result fields", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        owed_picks.push_back(spin_wheel(in_data));
      end
    end
    owed_count = owed_picks.size();
  end

endmodule

FILE: sim/roulette_wheel_selector_tb.sv
`timescale 1ns / 1ps

module roulette_wheel_selector_tb;

  import rws_pkg::*;

  localparam int CAPACITY    = 256;
  localparam int ITEM_TARGET = 1300;
  localparam int HOLD_CYCLES = 600;
  // quiet stretch: long hold-off plus a full-table draw, with plenty of margin
  localparam int QUIET_LIMIT = 6000;
  localparam int TAIL_CYCLES = 320;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  rws_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  rws_out_t out_data;

  int fault_count;
  int owed_count;
  int send_gap_pct = 24;
  int recv_gap_pct = 79;
  int sent_count   = 0;
  bit hold_req     = 1'b0;

  always #6 clk = ~clk;

  roulette_wheel_selector #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  roulette_wheel_selector_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fault_count(fault_count),
    .owed_count (owed_count)
  );

  // Result side: random stall, plus an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("roulette_wheel_selector: mismatch");
    $finish;
  end

  task automatic offer(input logic [1:0] op, input logic [31:0] fit, input logic [15:0] frac);
    rws_in_t item;
    item.op            = op;
    item.fitness_value = fit;
    item.rand_fraction = frac;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // stall seen before the edge decides the transfer
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent_count++;
  endtask

  task automatic clear_wheel();
    offer(OP_CLEAR, $urandom, 16'($urandom));
  endtask

  task automatic add_fitness(input logic [31:0] fit);
    offer(OP_APPEND, fit, 16'($urandom));
  endtask

  task automatic draw(input logic [15:0] frac);
    offer(OP_DRAW, $urandom, frac);
  endtask

  function automatic logic [31:0] pick_fitness(input int style);
    logic [31:0] v;
    case (style)
      0: v = $urandom;
      1: v = 32'($urandom_range(32'h0003_FFFF));
      2: v = -32'($urandom_range(32'h0003_FFFF));
      3: begin
        case ($urandom_range(3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = 32'($urandom_range(32'h0001_0000)) - 32'h0000_8000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int  style;
    int  steps;
    bit  filled;
    bit  phase1_held;
    bit  phase2_held;
    filled      = 1'b0;
    phase1_held = 1'b0;
    phase2_held = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    offer(OP_RSVD, $urandom, 16'($urandom));   // unused op on an empty wheel
    draw(16'hFFFF);                             // empty table
    clear_wheel();
    add_fitness(32'h7FFF_FFFF);
    add_fitness(32'h8000_0000);
    draw(16'h0000);
    draw(16'hFFFF);
    draw(16'h8000);
    // equal negatives: wheel collapses to zero width, uniform pick
    clear_wheel();
    repeat (3) add_fitness(32'hFFFB_0000);
    draw(16'hFFFF);
    draw(16'h0000);
    clear_wheel();
    add_fitness(32'h0);
    add_fitness(32'h0);
    draw(16'h4000);
    clear_wheel();
    add_fitness(32'h1);
    add_fitness(32'h3);
    draw(16'h0001);
    offer(OP_RSVD, $urandom, 16'($urandom));   // unused op leaves the table alone
    draw(16'hC000);

    // Random part: mostly well-formed clear/append/draw episodes
    while (sent_count < ITEM_TARGET) begin
      if (sent_count < ITEM_TARGET / 3) begin
        send_gap_pct = 24;
        recv_gap_pct = 79;
      end else if (sent_count < 2 * ITEM_TARGET / 3) begin
        send_gap_pct = 79;
        recv_gap_pct = 24;
        if (!phase1_held) begin
          phase1_held = 1'b1;
          hold_req    = 1'b1;
        end
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
        if (!phase2_held) begin
          phase2_held = 1'b1;
          hold_req    = 1'b1;
        end
      end

      style = $urandom_range(4);
      if (!filled && sent_count >= ITEM_TARGET / 3) begin
        // fill to capacity, then overflow it
        filled = 1'b1;
        clear_wheel();
        repeat (CAPACITY + 3) add_fitness(pick_fitness(style));
        repeat (4) draw(pick_frac());
      end else if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4)) offer(2'($urandom), $urandom, 16'($urandom));
      end else begin
        if ($urandom_range(4) != 0) clear_wheel();
        steps = ($urandom_range(7) == 0) ? $urandom_range(20, 45) : $urandom_range(2, 14);
        repeat (steps) begin
          if ($urandom_range(99) < 62) add_fitness(pick_fitness(style));
          else draw(pick_frac());
        end
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("roulette_wheel_selector: match");
    end else begin
      $display("roulette_wheel_selector: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/rws_pkg.sv
sv/rws_front.sv
sv/rws_queue.sv
sv/rws_back.sv
sv/roulette_wheel_selector.sv
sim/roulette_wheel_selector_checker.sv
sim/roulette_wheel_selector_tb.sv
